// File: hw/rtl/mandelbrot_escape_iterator_unit_macros.svh
// Assertion macros shared by the escape iterator RTL.
// Depends on nothing; files that assert take it by include.
`ifndef MANDELBROT_ESCAPE_ITERATOR_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_ITERATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define MEI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MEI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MEI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define MEI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/mei_pkg.sv
// Package for the escape iterator: payload structs, register indexes and the reset iteration limit.
// No dependencies.
`timescale 1ns / 1ps
package mei_pkg;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_MODE = 2'd1;
  localparam logic [15:0] MAX_ITER_RESET = 16'd224;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } pixel_t;

  typedef struct packed {
    logic [15:0] color;
    logic        escaped;
    logic [15:0] escape_index;
  } result_t;
endpackage

// File: hw/rtl/mei_mul.sv
// Shared signed multiplier with registered product.
// Depends on nothing.
`timescale 1ns / 1ps
module mei_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [33:0] b,
  output logic [63:0]        prod
);
  logic signed [65:0] full;
  assign full = a * b;
  always_ff @(posedge clk) begin
    prod <= full[63:0];
  end
endmodule

// File: hw/rtl/mei_div.sv
// Restoring serial divider, one quotient bit per cycle, 16-bit quotient.
// Depends on mei_pkg.
`timescale 1ns / 1ps
module mei_div import mei_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient
);
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] den;
  logic [5:0]  cnt;
  logic [16:0] trial;
  logic [17:0] diff;

  assign trial = {rem[15:0], quo[31]};
  assign diff = {1'b0, trial} - {2'b00, den};
  assign quotient = quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!diff[17]) begin
        rem <= diff[16:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end
endmodule

// File: hw/rtl/mandelbrot_escape_iterator_unit.sv
// Escape-time iterator top level: sequencer around one shared multiplier.
// Depends on mei_pkg, mei_mul, mei_div and the assertion macro header.
//
// Use: present a pixel on pixel/pixel_valid; it transfers when pixel_stall is
// low. pixel_stall stays high while an item is in work. One result per pixel
// leaves on result/result_valid and transfers when result_stall is low; the
// output register lets the next pixel transfer in while a result waits.
// From the input transfer to result_valid: a point inside the main cardioid
// goes from the cardioid test to the output register; otherwise the cardioid
// test and setup, a window step per window, three squares per iteration
// through the one 32x34 multiplier, a serial divide on escape and the load
// of the output register. The next pixel can transfer in the cycle after
// the result loads.
// Config: write max_iterations (index 0) or deep_mode (index 1) on cfg_wr,
// only while idle. Reset (rst, synchronous) sets 224 and deep mode, drops
// any work and empties the output register. A stalled receiver holds the
// result; a finished item waits in its last step until the register is free.
`timescale 1ns / 1ps
`include "mandelbrot_escape_iterator_unit_macros.svh"
module mandelbrot_escape_iterator_unit import mei_pkg::*; #(
  parameter int FRAC_NORMAL = 13,
  parameter int FRAC_DEEP = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);
  localparam logic [31:0] BOUND_D = 32'(64'd4 << FRAC_DEEP);
  localparam logic [31:0] BOUND_N = 32'(64'd4 << FRAC_NORMAL);
  localparam logic [31:0] QUART_D = 32'(64'd1 << (FRAC_DEEP - 2));
  localparam logic [31:0] QUART_N = 32'(64'd1 << (FRAC_NORMAL - 2));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_C0 = 4'd1;
  localparam logic [3:0] S_C1 = 4'd2;
  localparam logic [3:0] S_C2 = 4'd3;
  localparam logic [3:0] S_C3 = 4'd4;
  localparam logic [3:0] S_C4 = 4'd5;
  localparam logic [3:0] S_C5 = 4'd6;
  localparam logic [3:0] S_C6 = 4'd7;
  localparam logic [3:0] S_WIN = 4'd8;
  localparam logic [3:0] S_I1 = 4'd9;
  localparam logic [3:0] S_I2 = 4'd10;
  localparam logic [3:0] S_I3 = 4'd11;
  localparam logic [3:0] S_I4 = 4'd12;
  localparam logic [3:0] S_I5 = 4'd13;
  localparam logic [3:0] S_DIV = 4'd14;
  localparam logic [3:0] S_OUT = 4'd15;

  logic [3:0]  state;
  logic [15:0] max_iterations;
  logic        deep_mode;

  logic [31:0] cr, ci, t, q, tsq, cisq, zr, zi, zrs, zis, zsum, ckr, cki;
  logic [33:0] s;
  logic [15:0] p;
  logic [16:0] wend;
  logic [15:0] res_color, res_index;
  logic        res_esc;

  logic signed [31:0] mul_a;
  logic signed [33:0] mul_b;
  logic [63:0]        prod;
  logic [31:0]        sq;
  logic [31:0]        quarter, bound;
  logic [32:0]        rhs_sum;
  logic signed [63:0] lhs, rhs;
  logic [31:0]        zi_new, zr_new, mag;
  logic [16:0]        wend_dbl, wend_next;
  logic [16:0]        p_inc;
  logic               div_start;
  logic               div_done;
  logic               div_busy;
  logic [15:0]        div_q;
  logic [31:0]        div_num;
  logic               out_free;

  assign pixel_stall = (state != S_IDLE);
  assign quarter = deep_mode ? QUART_D : QUART_N;
  assign bound = deep_mode ? BOUND_D : BOUND_N;
  assign sq = deep_mode ? prod[FRAC_DEEP+31:FRAC_DEEP]
                        : 32'($signed(prod[31:0]) >>> FRAC_NORMAL);
  assign rhs_sum = {cisq[31], cisq} + (cisq[31] ? 33'd3 : 33'd0);
  assign rhs = 64'($signed(rhs_sum) >>> 2);
  assign lhs = deep_mode ? ($signed(prod) >>> FRAC_DEEP) : 64'($signed(sq));
  assign zi_new = sq - zrs - zis + ci;
  assign zr_new = zrs - zis + cr;
  assign mag = zrs + sq;
  assign wend_dbl = {wend[15:0], 1'b0};
  assign wend_next = (wend_dbl > {1'b0, max_iterations}) ? {1'b0, max_iterations}
                                                          : wend_dbl;
  assign p_inc = {1'b0, p} + 17'd1;
  assign div_num = {res_index, 16'd0} - {16'd0, res_index};
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    mul_a = $signed(zsum);
    mul_b = 34'($signed(zsum));
    case (state)
      S_C0: begin
        mul_a = $signed(t);
        mul_b = 34'($signed(t));
      end
      S_C1: begin
        mul_a = $signed(ci);
        mul_b = 34'($signed(ci));
      end
      S_C4: begin
        mul_a = $signed(q);
        mul_b = $signed(s);
      end
      S_C5: begin
        mul_a = $signed(cr);
        mul_b = 34'($signed(cr));
      end
      S_I3: begin
        mul_a = $signed(zr);
        mul_b = 34'($signed(zr));
      end
      S_I4: begin
        mul_a = $signed(zi);
        mul_b = 34'($signed(zi));
      end
      default: ;
    endcase
  end

  mei_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mei_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (max_iterations),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
      deep_mode <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MAX_ITER: max_iterations <= cfg_data;
        REG_DEEP_MODE: deep_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (pixel_valid) state <= S_C0;
        S_C0: state <= S_C1;
        S_C1: state <= S_C2;
        S_C2: state <= S_C3;
        S_C3: state <= S_C4;
        S_C4: state <= S_C5;
        S_C5: state <= (lhs < rhs) ? S_OUT : S_C6;
        S_C6: state <= S_WIN;
        S_WIN: state <= (wend_next == 17'd0) ? S_OUT : S_I1;
        S_I1: state <= S_I2;
        S_I2: state <= S_I3;
        S_I3: state <= S_I4;
        S_I4: state <= S_I5;
        S_I5: begin
          if ($signed(mag) > $signed(bound)) begin
            state <= S_DIV;
            div_start <= 1'b1;
          end else if (zr == ckr && zi == cki) begin
            state <= S_OUT;
          end else if (p_inc == wend) begin
            state <= (wend == {1'b0, max_iterations}) ? S_OUT : S_WIN;
          end else begin
            state <= S_I1;
          end
        end
        S_DIV: if (div_done) state <= S_OUT;
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cr <= pixel.c_real;
        ci <= pixel.c_imag;
        t <= pixel.c_real - quarter;
        res_color <= '0;
        res_index <= '0;
        res_esc <= 1'b0;
      end
      S_C1: tsq <= sq;
      S_C2: begin
        q <= tsq + sq;
        cisq <= sq;
      end
      S_C3: begin
        if (deep_mode) begin
          s <= {{2{q[31]}}, q} + {{2{cr[31]}}, cr} - {2'b00, quarter};
        end else begin
          s <= 34'($signed(q + t));
        end
      end
      S_C6: begin
        zr <= cr;
        zi <= ci;
        zrs <= sq;
        zis <= cisq;
        zsum <= cr + ci;
        p <= '0;
        wend <= 17'd8;
      end
      S_WIN: begin
        ckr <= zr;
        cki <= zi;
        wend <= wend_next;
      end
      S_I2: begin
        zi <= zi_new;
        zr <= zr_new;
      end
      S_I3: zsum <= zr + zi;
      S_I4: zrs <= sq;
      S_I5: begin
        zis <= sq;
        p <= p_inc[15:0];
        res_index <= p;
      end
      S_DIV: begin
        if (div_done) begin
          res_color <= div_q;
          res_esc <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          result.color <= res_color;
          result.escaped <= res_esc;
          result.escape_index <= res_esc ? res_index : 16'd0;
        end
      end
      default: ;
    endcase
  end

  `MEI_ASSERT_IMPL(a_not_esc_zero, clk, rst, result_valid && !result.escaped,
    result.color == 16'd0 && result.escape_index == 16'd0, "non-escape result not zero")
  `MEI_ASSERT_IMPL(a_index_range, clk, rst, result_valid && result.escaped,
    result.escape_index < max_iterations, "escape index beyond limit")
  `MEI_ASSERT_IMPL(a_div_owned, clk, rst, div_busy, state == S_DIV,
    "divider busy outside divide step")
  `MEI_ASSERT_IMPL(a_iter_window, clk, rst,
    state == S_I1 || state == S_I3 || state == S_I5,
    {1'b0, p} < wend, "iteration past window end")
endmodule

// File: bench/tb_mandelbrot_escape_iterator_unit.sv
// Self-checking bench for the escape-time iterator unit: random and directed pixels,
// each checked against an in-bench fixed-point predictor. Depends on mei_pkg and the RTL.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_iterator_unit import mei_pkg::*; ;

  localparam int FRAC_N = 13;
  localparam int FRAC_D = 26;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  logic [15:0] cur_limit = MAX_ITER_RESET;
  logic        cur_deep = 1'b1;

  mandelbrot_escape_iterator_unit u_dut (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #10 clk = ~clk;

  class escape_scoreboard;
    result_t pending_colors[$];
    int      errors = 0;

    function void note_pixel(result_t exp_res);
      pending_colors.push_back(exp_res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      if (got.color !== want.color) begin
        $display("%0t: color exp %0d got %0d", $time, want.color, got.color);
        errors++;
      end
      if (got.escaped !== want.escaped) begin
        $display("%0t: escaped exp %0d got %0d", $time, want.escaped, got.escaped);
        errors++;
      end
      if (got.escape_index !== want.escape_index) begin
        $display("%0t: escape_index exp %0d got %0d", $time, want.escape_index,
                 got.escape_index);
        errors++;
      end
    endfunction
  endclass

  escape_scoreboard sb = new();

  function automatic int fx_square(int x, bit deep);
    longint p;
    int w;
    if (deep) begin
      p = longint'(x) * longint'(x);
      return int'(p >>> FRAC_D);
    end
    w = x * x;
    return w >>> FRAC_N;
  endfunction

  function automatic bit in_main_cardioid(int cr, int ci, bit deep);
    int quarter, t, q, rhs, s, w;
    longint sl, prod, lhs;
    quarter = deep ? (1 << (FRAC_D - 2)) : (1 << (FRAC_N - 2));
    t = cr - quarter;
    q = fx_square(t, deep) + fx_square(ci, deep);
    rhs = fx_square(ci, deep) / 4;
    if (deep) begin
      sl = longint'(q) + (longint'(cr) - longint'(quarter));
      prod = longint'(q) * sl;
      lhs = prod >>> FRAC_D;
    end else begin
      s = q + t;
      w = q * s;
      lhs = longint'(w >>> FRAC_N);
    end
    return lhs < longint'(rhs);
  endfunction

  function automatic result_t escape_color(pixel_t px, logic [15:0] limit, bit deep,
                                           output int unsigned steps);
    result_t r;
    int cr, ci, zr, zi, zrs, zis, ckr, cki, bound;
    int unsigned p, wend;
    longint scaled;
    r = '0;
    steps = 0;
    cr = px.c_real;
    ci = px.c_imag;
    if (in_main_cardioid(cr, ci, deep)) return r;
    bound = deep ? (4 << FRAC_D) : (4 << FRAC_N);
    zr = cr;
    zi = ci;
    zrs = fx_square(zr, deep);
    zis = fx_square(zi, deep);
    p = 0;
    wend = 8;
    do begin
      ckr = zr;
      cki = zi;
      wend = wend + wend;
      if (wend > limit) wend = limit;
      while (p < wend) begin
        steps = p + 1;
        zi = fx_square(zr + zi, deep) - zrs - zis + ci;
        zr = zrs - zis + cr;
        zrs = fx_square(zr, deep);
        zis = fx_square(zi, deep);
        if (zrs + zis > bound) begin
          scaled = longint'(p) * 65535 / longint'(limit);
          r.color = scaled[15:0];
          r.escaped = 1'b1;
          r.escape_index = p[15:0];
          return r;
        end
        if (zr == ckr && zi == cki) return r;
        p++;
      end
    end while (wend != limit);
    return r;
  endfunction

  function automatic int idle_len();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 80);
    return n;
  endfunction

  task automatic send_pixel(pixel_t px);
    int unsigned steps;
    int gap;
    pixel_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (pixel_stall);
    sb.note_pixel(escape_color(px, cur_limit, cur_deep, steps));
    if ($urandom_range(0, 2) != 0) begin
      gap = idle_len();
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_MAX_ITER) cur_limit = val;
    else if (idx == REG_DEEP_MODE) cur_deep = val[0];
  endtask

  task automatic set_mode(logic [15:0] limit, logic [15:0] deep_word);
    drain();
    write_reg(REG_MAX_ITER, limit);
    write_reg(REG_DEEP_MODE, deep_word);
    write_reg(REG_SPARE, 16'($urandom()));
    cfg_wr <= 1'b0;
  endtask

  function automatic int fx_const(int num, int den);
    int frac;
    frac = cur_deep ? FRAC_D : FRAC_N;
    return int'((longint'(num) <<< frac) / den);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int span, k;
    span = cur_deep ? (1 << FRAC_D) : (1 << FRAC_N);
    k = $urandom_range(0, 99);
    if (k < 60) begin
      px.c_real = int'($urandom_range(0, 4 * span - 1)) - 2 * span;
      px.c_imag = int'($urandom_range(0, 4 * span - 1)) - 2 * span;
    end else if (k < 85) begin
      px.c_real = int'($urandom_range(0, span - 1)) - span;
      px.c_imag = int'($urandom_range(0, span)) - span / 2;
    end else begin
      px.c_real = $urandom();
      px.c_imag = $urandom();
    end
    return px;
  endfunction

  task automatic run_directed();
    pixel_t px;
    int one;
    one = fx_const(1, 1);
    px = '{32'sd0, 32'sd0};                       send_pixel(px);
    px = '{32'h7FFFFFFF, 32'h7FFFFFFF};            send_pixel(px);
    px = '{32'h80000000, 32'h80000000};            send_pixel(px);
    px = '{32'h80000000, 32'sd0};                  send_pixel(px);
    px = '{32'sd0, 32'h7FFFFFFF};                  send_pixel(px);
    px = '{-32'sd1, -32'sd1};                      send_pixel(px);
    px = '{2 * one, 0};                            send_pixel(px);
    px = '{-one, 0};                               send_pixel(px);
    px = '{-2 * one, 0};                           send_pixel(px);
    px = '{fx_const(1, 4), 0};                     send_pixel(px);
    px = '{fx_const(26, 100), 0};                  send_pixel(px);
    px = '{fx_const(-3, 4), fx_const(1, 10)};      send_pixel(px);
    px = '{fx_const(3, 10), fx_const(1, 2)};       send_pixel(px);
    px = '{fx_const(-1, 8), fx_const(3, 4)};       send_pixel(px);
    px = '{0, one};                                send_pixel(px);
    px = '{fx_const(1, 2), fx_const(1, 2)};        send_pixel(px);
    px = '{32'h55555555, 32'hAAAAAAAA};            send_pixel(px);
    px = '{32'hAAAAAAAA, 32'h55555555};            send_pixel(px);
  endtask

  task automatic run_random(int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic run_short_only(int count);
    pixel_t px;
    int unsigned steps;
    result_t r;
    repeat (count) begin
      do begin
        px = random_pixel();
        r = escape_color(px, cur_limit, cur_deep, steps);
      end while (steps > 200);
      send_pixel(px);
    end
  endtask

  initial begin
    int n;
    forever begin
      n = $urandom_range(0, 99);
      if (n < 40) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (n < 95) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(30, 90)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(200);
    set_mode(16'd16, 16'hFFFE);
    run_directed();
    run_random(400);
    set_mode(16'd1, 16'd1);
    run_random(150);
    set_mode(16'd0, 16'd0);
    run_random(50);
    set_mode(16'd64, 16'd1);
    run_random(400);
    set_mode(16'd40, 16'd0);
    run_random(400);
    set_mode(16'hFFFF, 16'd1);
    run_short_only(15);
    set_mode(16'hFFFF, 16'd0);
    run_short_only(15);
    set_mode(16'd100, 16'hFFFF);
    run_random(250);
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_colors.size() == 0) begin
      $display("tb_mandelbrot_escape_iterator_unit: done, clean");
    end else begin
      $display("tb_mandelbrot_escape_iterator_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("tb_mandelbrot_escape_iterator_unit: done, errors");
    $finish;
  end
endmodule
